// ----- rtl/core/cawc_pkg.sv -----
package cawc_pkg;

    // Item kinds on the input channel
    localparam logic KIND_CARD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_ADD_ADMIN = 2'd0;
    localparam logic [1:0] CFG_DEL_ADMIN = 2'd1;
    localparam logic [1:0] CFG_WIN_TICKS = 2'd2;

    localparam logic [7:0]  WIN_TICKS_RST = 8'd100;
    localparam logic [31:0] ID_BLANK_LO   = 32'h0000_0000;
    localparam logic [31:0] ID_BLANK_HI   = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        EV_REPEAT    = 4'd0,
        EV_GRANTED   = 4'd1,
        EV_DENIED    = 4'd2,
        EV_ADD_ENTER = 4'd3,
        EV_ADDED     = 4'd4,
        EV_EXISTS    = 4'd5,
        EV_FULL      = 4'd6,
        EV_ADD_LEAVE = 4'd7,
        EV_DEL_ENTER = 4'd8,
        EV_DELETED   = 4'd9,
        EV_NOT_FOUND = 4'd10,
        EV_DEL_LEAVE = 4'd11,
        EV_CLEARED   = 4'd12
    } t_event;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ADD    = 2'd1,
        MODE_DELETE = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_ADD    = 2'd1,
        OP_DEL    = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_INIT   = 3'd0,
        ST_IDLE   = 3'd1,
        ST_SCAN   = 3'd2,
        ST_DECIDE = 3'd3,
        ST_CLEAR  = 3'd4,
        ST_DONE   = 3'd5
    } t_state;

    typedef struct packed {
        logic        kind;
        logic [31:0] card_id;
        logic        clear_button_held;
    } t_in_item;

    typedef struct packed {
        t_event     event_res;
        logic [5:0] slot;
        logic       door_open;
    } t_out_item;

    // Admin identities from the configuration registers
    typedef struct packed {
        logic [31:0] add_admin;
        logic [31:0] del_admin;
    } t_admin_ids;

endpackage

// ----- rtl/core/cawc_ram.sv -----
module cawc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ----- rtl/core/cawc_window.sv -----
module cawc_window (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_read_acc,
    input  logic        i_tick_acc,
    input  logic [31:0] i_card_id,
    input  logic [7:0]  i_win_ticks,
    output logic        o_repeat
);

    logic        r_active;
    logic [31:0] r_last;
    logic [7:0]  r_count;
    logic [7:0]  n_count;

    assign o_repeat = r_active && (i_card_id == r_last);
    assign n_count  = r_count + 8'd1;

    // Open the window on a fresh read, count its ticks up to the window length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_last   <= '0;
            r_count  <= '0;
        end else if (i_read_acc && !o_repeat) begin
            r_last   <= i_card_id;
            r_active <= 1'b1;
        end else if (i_tick_acc && r_active) begin
            if (n_count >= i_win_ticks) begin
                r_active <= 1'b0;
                r_count  <= '0;
            end else begin
                r_count <= n_count;
            end
        end
    end

endmodule

// ----- rtl/core/cawc_seq.sv -----
module cawc_seq #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  cawc_pkg::t_in_item   i_item,
    input  logic                 i_repeat,
    input  cawc_pkg::t_admin_ids i_admin,
    output logic                 o_busy,
    output logic                 o_res_valid,
    input  logic                 i_res_take,
    output cawc_pkg::t_out_item  o_res
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);
    localparam logic [AW:0]   ENTRIES  = (AW + 1)'(TABLE_ENTRIES);

    cawc_pkg::t_state r_state, n_state;
    cawc_pkg::t_mode  r_mode, d_mode;
    cawc_pkg::t_op    r_op, d_op;
    cawc_pkg::t_event r_res, d_ev;
    logic             d_go_scan, d_go_clear;

    logic [AW:0]   r_cnt;
    logic          r_chk_valid;
    logic [AW-1:0] r_chk_idx;
    logic [31:0]   r_id;
    logic          r_hit, r_blank_found;
    logic [AW-1:0] r_hit_idx, r_blank_idx, r_slot_idx;

    logic          rd_more, clr_last, chk_last, id_blank;
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0]   ram_wdata, ram_rdata;
    logic          row_match, row_blank;
    logic [AW+5:0] slot_ext;

    cawc_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_more   = r_cnt < ENTRIES;
    assign clr_last  = r_cnt[AW-1:0] == LAST_IDX;
    assign chk_last  = r_chk_idx == LAST_IDX;
    assign id_blank  = (i_item.card_id == cawc_pkg::ID_BLANK_LO) ||
                       (i_item.card_id == cawc_pkg::ID_BLANK_HI);
    assign row_match = ram_rdata == r_id;
    assign row_blank = (ram_rdata == cawc_pkg::ID_BLANK_LO) ||
                       (ram_rdata == cawc_pkg::ID_BLANK_HI);

    // Decode a card read against mode and admin identities
    always_comb begin
        d_mode     = r_mode;
        d_op       = cawc_pkg::OP_LOOKUP;
        d_ev       = cawc_pkg::EV_DENIED;
        d_go_scan  = 1'b0;
        d_go_clear = 1'b0;
        if (i_repeat) begin
            d_ev = cawc_pkg::EV_REPEAT;
        end else begin
            case (r_mode)
                cawc_pkg::MODE_ADD: begin
                    if (i_item.card_id == i_admin.add_admin) begin
                        d_mode = cawc_pkg::MODE_NORMAL;
                        d_ev   = cawc_pkg::EV_ADD_LEAVE;
                    end else if (id_blank) begin
                        d_ev = cawc_pkg::EV_DENIED;
                    end else begin
                        d_op      = cawc_pkg::OP_ADD;
                        d_go_scan = 1'b1;
                    end
                end
                cawc_pkg::MODE_DELETE: begin
                    if (i_item.card_id == i_admin.del_admin) begin
                        d_mode = cawc_pkg::MODE_NORMAL;
                        d_ev   = cawc_pkg::EV_DEL_LEAVE;
                    end else if (id_blank) begin
                        d_ev = cawc_pkg::EV_NOT_FOUND;
                    end else begin
                        d_op      = cawc_pkg::OP_DEL;
                        d_go_scan = 1'b1;
                    end
                end
                default: begin
                    if (i_item.card_id == i_admin.add_admin) begin
                        d_mode = cawc_pkg::MODE_ADD;
                        d_ev   = cawc_pkg::EV_ADD_ENTER;
                    end else if (i_item.card_id == i_admin.del_admin) begin
                        if (i_item.clear_button_held) begin
                            d_mode     = cawc_pkg::MODE_NORMAL;
                            d_ev       = cawc_pkg::EV_CLEARED;
                            d_go_clear = 1'b1;
                        end else begin
                            d_mode = cawc_pkg::MODE_DELETE;
                            d_ev   = cawc_pkg::EV_DEL_ENTER;
                        end
                    end else if (id_blank) begin
                        d_ev = cawc_pkg::EV_DENIED;
                    end else begin
                        d_go_scan = 1'b1;
                    end
                end
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cawc_pkg::ST_INIT: begin
                if (clr_last) n_state = cawc_pkg::ST_IDLE;
            end
            cawc_pkg::ST_IDLE: begin
                if (i_accept) begin
                    if (d_go_clear)     n_state = cawc_pkg::ST_CLEAR;
                    else if (d_go_scan) n_state = cawc_pkg::ST_SCAN;
                    else                n_state = cawc_pkg::ST_DONE;
                end
            end
            cawc_pkg::ST_SCAN: begin
                if (r_chk_valid && chk_last) n_state = cawc_pkg::ST_DECIDE;
            end
            cawc_pkg::ST_DECIDE: begin
                n_state = cawc_pkg::ST_DONE;
            end
            cawc_pkg::ST_CLEAR: begin
                if (clr_last) n_state = cawc_pkg::ST_DONE;
            end
            cawc_pkg::ST_DONE: begin
                if (i_res_take) n_state = cawc_pkg::ST_IDLE;
            end
            default: begin
                n_state = cawc_pkg::ST_IDLE;
            end
        endcase
    end

    // Table port control per state
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cnt[AW-1:0];
        ram_wdata = cawc_pkg::ID_BLANK_LO;
        ram_re    = 1'b0;
        ram_raddr = r_cnt[AW-1:0];
        o_busy    = 1'b1;
        o_res_valid = 1'b0;
        case (r_state)
            cawc_pkg::ST_INIT, cawc_pkg::ST_CLEAR: begin
                ram_we = 1'b1;
            end
            cawc_pkg::ST_IDLE: begin
                o_busy = 1'b0;
            end
            cawc_pkg::ST_SCAN: begin
                ram_re    = rd_more;
                ram_waddr = r_chk_idx;
                ram_we    = (r_op == cawc_pkg::OP_DEL) && r_chk_valid && row_match;
            end
            cawc_pkg::ST_DECIDE: begin
                ram_waddr = r_blank_idx;
                ram_wdata = r_id;
                ram_we    = (r_op == cawc_pkg::OP_ADD) && !r_hit && r_blank_found;
            end
            cawc_pkg::ST_DONE: begin
                o_res_valid = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cawc_pkg::ST_INIT;
            r_mode      <= cawc_pkg::MODE_NORMAL;
            r_cnt       <= '0;
            r_chk_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_chk_valid <= (r_state == cawc_pkg::ST_SCAN) && rd_more;
            if (r_state == cawc_pkg::ST_IDLE) begin
                r_cnt <= '0;
                if (i_accept) r_mode <= d_mode;
            end else if (r_state == cawc_pkg::ST_INIT || r_state == cawc_pkg::ST_CLEAR ||
                         (r_state == cawc_pkg::ST_SCAN && rd_more)) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // Scan bookkeeping and result
    always_ff @(posedge i_clk) begin
        r_chk_idx <= r_cnt[AW-1:0];
        case (r_state)
            cawc_pkg::ST_IDLE: begin
                if (i_accept) begin
                    r_id          <= i_item.card_id;
                    r_op          <= d_op;
                    r_res         <= d_ev;
                    r_hit         <= 1'b0;
                    r_blank_found <= 1'b0;
                    r_hit_idx     <= '0;
                    r_blank_idx   <= '0;
                    r_slot_idx    <= '0;
                end
            end
            cawc_pkg::ST_SCAN: begin
                if (r_chk_valid && row_match && !r_hit) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_chk_idx;
                end
                if (r_chk_valid && row_blank && !r_blank_found) begin
                    r_blank_found <= 1'b1;
                    r_blank_idx   <= r_chk_idx;
                end
            end
            cawc_pkg::ST_DECIDE: begin
                case (r_op)
                    cawc_pkg::OP_ADD: begin
                        if (r_hit) begin
                            r_res <= cawc_pkg::EV_EXISTS;
                        end else if (r_blank_found) begin
                            r_res      <= cawc_pkg::EV_ADDED;
                            r_slot_idx <= r_blank_idx;
                        end else begin
                            r_res <= cawc_pkg::EV_FULL;
                        end
                    end
                    cawc_pkg::OP_DEL: begin
                        if (r_hit) begin
                            r_res      <= cawc_pkg::EV_DELETED;
                            r_slot_idx <= r_hit_idx;
                        end else begin
                            r_res <= cawc_pkg::EV_NOT_FOUND;
                        end
                    end
                    default: begin
                        r_res <= r_hit ? cawc_pkg::EV_GRANTED : cawc_pkg::EV_DENIED;
                    end
                endcase
            end
            default: begin
                r_hit <= r_hit;
            end
        endcase
    end

    // Slot reports the index modulo 64
    assign slot_ext        = {6'd0, r_slot_idx};
    assign o_res.event_res = r_res;
    assign o_res.slot      = slot_ext[5:0];
    assign o_res.door_open = r_res == cawc_pkg::EV_GRANTED;

endmodule

// ----- rtl/core/card_access_whitelist_controller.sv -----
// Card read: a decision that needs no table walk goes straight to the result;
// otherwise the table is walked (one slot read per cycle through the single read
// port of the card table), or, for clear-all, swept to zero before the result.
// Timer ticks give no result. One item is in work at a time.
// Reset: synchronous, active low; afterwards the table is swept to zero, one
// slot per cycle, before the first item is taken.
module card_access_whitelist_controller #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  cawc_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output cawc_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);

    cawc_pkg::t_admin_ids r_admin;
    logic [7:0]           r_win_ticks;
    logic                 r_out_valid;
    cawc_pkg::t_out_item  r_out_data;

    logic                w_busy, w_repeat, w_res_valid, w_res_take;
    logic                w_in_acc, w_read_acc, w_tick_acc;
    cawc_pkg::t_out_item w_res;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_busy;
    assign w_in_acc    = i_in_valid && !w_busy;
    assign w_read_acc  = w_in_acc && (i_in_data.kind == cawc_pkg::KIND_CARD);
    assign w_tick_acc  = w_in_acc && (i_in_data.kind == cawc_pkg::KIND_TICK);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_admin.add_admin <= '0;
            r_admin.del_admin <= '0;
            r_win_ticks       <= cawc_pkg::WIN_TICKS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                cawc_pkg::CFG_ADD_ADMIN: r_admin.add_admin <= i_cfg_data;
                cawc_pkg::CFG_DEL_ADMIN: r_admin.del_admin <= i_cfg_data;
                cawc_pkg::CFG_WIN_TICKS: r_win_ticks       <= i_cfg_data[7:0];
                default:                 r_win_ticks       <= r_win_ticks;
            endcase
        end
    end

    cawc_window u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_read_acc  (w_read_acc),
        .i_tick_acc  (w_tick_acc),
        .i_card_id   (i_in_data.card_id),
        .i_win_ticks (r_win_ticks),
        .o_repeat    (w_repeat)
    );

    cawc_seq #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_read_acc),
        .i_item      (i_in_data),
        .i_repeat    (w_repeat),
        .i_admin     (r_admin),
        .o_busy      (w_busy),
        .o_res_valid (w_res_valid),
        .i_res_take  (w_res_take),
        .o_res       (w_res)
    );

    // Output register: load when empty or being drained
    assign w_res_take = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_take) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_take && w_res_valid) begin
            r_out_data <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Slot is only reported for add and delete
    a_slot_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.slot != 6'd0) |->
        (o_out_data.event_res == cawc_pkg::EV_ADDED ||
         o_out_data.event_res == cawc_pkg::EV_DELETED))
        else $error("slot reported for an event that writes no slot");

    // Sequencer holds its result until the output register takes it
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && !w_res_take) |=> (w_res_valid && $stable(w_res)))
        else $error("sequencer result dropped or changed while waiting");

    // Output only becomes valid from a sequencer result
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_res_valid))
        else $error("output valid without a sequencer result");

    // No item enters while a sequencer result is pending
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && i_in_valid) |-> o_in_stall)
        else $error("item accepted while a result is pending");

endmodule

// ----- tb/sv/whitelist_scoreboard.sv -----
`timescale 1ns / 1ps

module whitelist_scoreboard
    import cawc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_item    i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_item   i_out_data,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    // Shadow of the whitelist and the access state
    logic [31:0] card_slots [TABLE_ENTRIES];
    t_mode       door_mode;
    logic [31:0] last_id;
    logic        window_open;
    logic [7:0]  window_ticks;

    // Shadow of the configuration registers
    logic [31:0] add_admin_id;
    logic [31:0] del_admin_id;
    logic [7:0]  window_len;

    t_out_item   due_events [$];
    int          fail_count;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        fail_count   = 0;
    end

    function automatic bit is_blank(input logic [31:0] id);
        return (id == ID_BLANK_LO) || (id == ID_BLANK_HI);
    endfunction

    function automatic bit is_enrolled(input logic [31:0] id);
        if (is_blank(id)) begin
            return 1'b0;
        end
        foreach (card_slots[i]) begin
            if (card_slots[i] == id) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Advance the shadow state by one item; return 1 when a result is due
    function automatic bit decide_access(input t_in_item it, output t_out_item res);
        logic [31:0] id;
        bit          found;
        id    = it.card_id;
        found = 1'b0;
        res   = '0;
        res.event_res = EV_REPEAT;

        // Ticks only age an open repeat window
        if (it.kind == KIND_TICK) begin
            if (window_open) begin
                window_ticks = window_ticks + 8'd1;
                if (window_ticks >= window_len) begin
                    window_open  = 1'b0;
                    window_ticks = 8'd0;
                end
            end
            return 1'b0;
        end

        // Report a repeat of the last card while the window is open
        if (window_open && id == last_id) begin
            return 1'b1;
        end
        last_id     = id;
        window_open = 1'b1;

        case (door_mode)
            MODE_ADD: begin
                if (id == add_admin_id) begin
                    door_mode     = MODE_NORMAL;
                    res.event_res = EV_ADD_LEAVE;
                end else if (is_blank(id)) begin
                    res.event_res = EV_DENIED;
                end else if (is_enrolled(id)) begin
                    res.event_res = EV_EXISTS;
                end else begin
                    // Take the first blank slot, else report a full table
                    res.event_res = EV_FULL;
                    for (int i = 0; i < TABLE_ENTRIES; i++) begin
                        if (is_blank(card_slots[i])) begin
                            card_slots[i] = id;
                            res.event_res = EV_ADDED;
                            res.slot      = 6'(i);
                            break;
                        end
                    end
                end
            end
            MODE_DELETE: begin
                if (id == del_admin_id) begin
                    door_mode     = MODE_NORMAL;
                    res.event_res = EV_DEL_LEAVE;
                end else if (is_enrolled(id)) begin
                    // Clear every matching slot, report the first one
                    res.event_res = EV_DELETED;
                    for (int i = 0; i < TABLE_ENTRIES; i++) begin
                        if (card_slots[i] == id) begin
                            card_slots[i] = '0;
                            if (!found) begin
                                res.slot = 6'(i);
                                found    = 1'b1;
                            end
                        end
                    end
                end else begin
                    res.event_res = EV_NOT_FOUND;
                end
            end
            default: begin
                if (id == add_admin_id) begin
                    door_mode     = MODE_ADD;
                    res.event_res = EV_ADD_ENTER;
                end else if (id == del_admin_id) begin
                    if (it.clear_button_held) begin
                        foreach (card_slots[i]) begin
                            card_slots[i] = '0;
                        end
                        door_mode     = MODE_NORMAL;
                        res.event_res = EV_CLEARED;
                    end else begin
                        door_mode     = MODE_DELETE;
                        res.event_res = EV_DEL_ENTER;
                    end
                end else if (is_enrolled(id)) begin
                    res.event_res = EV_GRANTED;
                    res.door_open = 1'b1;
                end else begin
                    res.event_res = EV_DENIED;
                end
            end
        endcase
        return 1'b1;
    endfunction

    // Watch all three channels at each rising edge
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        t_out_item next_res;
        if (!i_rst_n) begin
            foreach (card_slots[i]) begin
                card_slots[i] = '0;
            end
            door_mode    = MODE_NORMAL;
            last_id      = '0;
            window_open  = 1'b0;
            window_ticks = '0;
            add_admin_id = '0;
            del_admin_id = '0;
            window_len   = WIN_TICKS_RST;
            due_events.delete();
        end else begin
            // Compare a result transfer against the oldest expectation
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (due_events.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual event %0d slot %0d door %0b",
                             $time, got.event_res, got.slot, got.door_open);
                    fail_count++;
                end else begin
                    want = due_events.pop_front();
                    if (got.event_res !== want.event_res) begin
                        $display("%0t: event_res expected %0d actual %0d",
                                 $time, want.event_res, got.event_res);
                    end
                    if (got.slot !== want.slot) begin
                        $display("%0t: slot expected %0d actual %0d",
                                 $time, want.slot, got.slot);
                    end
                    if (got.door_open !== want.door_open) begin
                        $display("%0t: door_open expected %0b actual %0b",
                                 $time, want.door_open, got.door_open);
                    end
                    if (got !== want) begin
                        fail_count++;
                    end
                end
            end

            // Predict from an accepted input transfer
            if (i_in_valid && !i_in_stall) begin
                if (decide_access(i_in_data, next_res)) begin
                    due_events.push_back(next_res);
                end
            end

            // Track register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ADD_ADMIN: add_admin_id = i_cfg_data;
                    CFG_DEL_ADMIN: del_admin_id = i_cfg_data;
                    CFG_WIN_TICKS: window_len   = i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
        o_pending    <= due_events.size();
        o_fail_count <= fail_count;
    end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import cawc_pkg::*;

    localparam int          TABLE_ENTRIES    = 64;
    localparam int          POOL_SIZE        = 72;
    localparam int          RANDOM_PER_PHASE = 400;
    localparam int          SETTLE_CYCLES    = TABLE_ENTRIES + 16;
    localparam int          CYCLE_LIMIT      = 4000000;
    localparam logic [31:0] ADMIN_ADD_A      = 32'h1234_5678;
    localparam logic [31:0] ADMIN_DEL_A      = 32'h8765_4321;
    localparam logic [31:0] GUEST_CARD       = 32'hDEAD_BEEF;
    localparam logic [31:0] STRANGER_CARD    = 32'h0BAD_F00D;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} t_stall_style;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_ADD_ADMIN;
    logic [31:0] i_cfg_data  = '0;

    int          fail_count;
    int          pending;

    logic [31:0] card_pool [POOL_SIZE];
    logic [31:0] cur_add;
    logic [31:0] cur_del;
    logic [7:0]  cur_win;
    int          burst_left  = 0;
    int          items_sent  = 0;
    int          cycle_count = 0;
    t_stall_style stall_style = STALL_NONE;
    int          stall_span  = 0;

    card_access_whitelist_controller #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    whitelist_scoreboard #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Give up on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL card_access_whitelist_controller");
            $finish;
        end
    end

    // Result-side backpressure: switch between no, light and heavy stalling
    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_style <= t_stall_style'($urandom_range(0, 2));
            stall_span  <= $urandom_range(40, 400);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_style)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 2) == 0);
            default:     i_out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Send one item in bursts with random gaps; hold it until the transfer
    task automatic push_item(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0) begin
                gap = 0;
            end else if ($urandom_range(0, 9) == 0) begin
                gap = $urandom_range(1, 90);
            end else begin
                gap = $urandom_range(1, 6);
            end
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        burst_left--;
        items_sent++;
    endtask

    task automatic present(input logic [31:0] id, input logic clr);
        t_in_item it;
        it.kind              = KIND_CARD;
        it.card_id           = id;
        it.clear_button_held = clr;
        push_item(it);
    endtask

    task automatic ticks(input int n);
        t_in_item it;
        repeat (n) begin
            it.kind              = KIND_TICK;
            it.card_id           = $urandom;
            it.clear_button_held = 1'($urandom_range(0, 1));
            push_item(it);
        end
    endtask

    // Read a known card, sometimes after ticks, sometimes twice in a row
    task automatic pool_read();
        logic [31:0] id;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            ticks($urandom_range(1, 3));
        end else if (r < 23) begin
            ticks($urandom_range(1, int'(cur_win) + 1));
        end
        id = card_pool[$urandom_range(0, POOL_SIZE - 1)];
        present(id, $urandom_range(0, 15) == 0);
        if ($urandom_range(0, 9) == 0) begin
            present(id, 1'b0);
        end
    endtask

    task automatic run_sequence();
        int          pick;
        t_in_item    it;
        pick = $urandom_range(0, 99);
        if (pick < 28) begin
            // Enroll a few cards
            present(cur_add, 1'b0);
            repeat ($urandom_range(1, 24)) pool_read();
            present(cur_add, 1'b0);
        end else if (pick < 50) begin
            // Remove a few cards
            present(cur_del, 1'b0);
            repeat ($urandom_range(1, 10)) pool_read();
            present(cur_del, 1'b0);
        end else if (pick < 78) begin
            repeat ($urandom_range(1, 16)) pool_read();
        end else if (pick < 82) begin
            present(cur_del, 1'b1);
        end else if (pick < 84) begin
            // Walk the whole pool in add mode so the table runs full
            present(cur_add, 1'b0);
            foreach (card_pool[k]) begin
                if ($urandom_range(0, 7) == 0) begin
                    ticks(1);
                end
                present(card_pool[k], 1'b0);
            end
            present(cur_add, 1'b0);
        end else begin
            // Noise: any kind, odd IDs, random clear button
            repeat ($urandom_range(1, 8)) begin
                it.kind              = $urandom_range(0, 1) ? KIND_TICK : KIND_CARD;
                it.clear_button_held = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 5))
                    0:       it.card_id = $urandom;
                    1:       it.card_id = ID_BLANK_LO;
                    2:       it.card_id = ID_BLANK_HI;
                    3:       it.card_id = cur_add;
                    4:       it.card_id = cur_del;
                    default: it.card_id = card_pool[$urandom_range(0, POOL_SIZE - 1)];
                endcase
                push_item(it);
            end
        end
    endtask

    // Write one register, keeping valid high across back-to-back writes
    task automatic cfg_put(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic configure();
        logic [31:0] win_word;
        win_word       = $urandom;
        win_word[7:0]  = cur_win;
        cfg_put(CFG_ADD_ADMIN, cur_add);
        cfg_put(CFG_DEL_ADMIN, cur_del);
        cfg_put(CFG_WIN_TICKS, win_word);
        i_cfg_valid <= 1'b0;
    endtask

    // Let every result come back and the block go quiet
    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic directed_checks();
        present(32'h0000_0001, 1'b0);   // unknown card denied
        present(ID_BLANK_LO, 1'b0);     // blank IDs denied in normal mode
        present(ID_BLANK_HI, 1'b0);
        present(ID_BLANK_HI, 1'b0);     // repeat inside the window
        ticks(1);
        present(ID_BLANK_HI, 1'b0);
        present(ADMIN_ADD_A, 1'b0);     // enter add mode
        present(GUEST_CARD, 1'b0);
        present(GUEST_CARD, 1'b0);
        ticks(1);
        present(GUEST_CARD, 1'b0);      // already enrolled
        present(ID_BLANK_LO, 1'b0);
        present(ID_BLANK_HI, 1'b1);
        present(ADMIN_DEL_A, 1'b0);     // delete admin is an ordinary card here
        present(ADMIN_ADD_A, 1'b0);     // leave add mode
        present(GUEST_CARD, 1'b0);      // door opens
        present(ADMIN_DEL_A, 1'b0);     // enter delete mode
        present(GUEST_CARD, 1'b0);
        present(STRANGER_CARD, 1'b0);
        present(ID_BLANK_LO, 1'b0);
        present(ADMIN_ADD_A, 1'b0);     // add admin is an ordinary card here
        present(ADMIN_DEL_A, 1'b0);     // leave delete mode
        ticks(1);
        present(ADMIN_DEL_A, 1'b1);     // clear the whole table
    endtask

    function automatic logic [31:0] random_card();
        logic [31:0] v;
        do v = $urandom; while (v == ID_BLANK_LO || v == ID_BLANK_HI);
        return v;
    endfunction

    initial begin
        int target;
        foreach (card_pool[k]) begin
            card_pool[k] = random_card();
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 5; phase++) begin
            // Pick admin cards and window length for this phase
            case (phase)
                0: begin
                    cur_add = ADMIN_ADD_A;
                    cur_del = ADMIN_DEL_A;
                    cur_win = 8'd1;
                end
                1: begin
                    cur_add = ID_BLANK_LO;
                    cur_del = ID_BLANK_HI;
                    cur_win = 8'd255;
                end
                2: begin
                    // Same card for both admins; add wins
                    cur_add = random_card();
                    cur_del = cur_add;
                    cur_win = 8'd0;
                end
                3: begin
                    cur_add = ID_BLANK_HI;
                    cur_del = ID_BLANK_LO;
                    cur_win = 8'($urandom_range(2, 30));
                end
                default: begin
                    cur_add = random_card();
                    cur_del = random_card();
                    cur_win = WIN_TICKS_RST;
                end
            endcase
            configure();
            if (phase == 0) begin
                directed_checks();
            end
            target = items_sent + RANDOM_PER_PHASE;
            while (items_sent < target) run_sequence();
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("PASS card_access_whitelist_controller");
        end else begin
            $display("FAIL card_access_whitelist_controller");
        end
        $finish;
    end

endmodule
